/* src/rtp_jitter_slot_tracker_assert.svh */
// Assertion shorthands shared by the tracker's modules.
// Each expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef RTP_JITTER_SLOT_TRACKER_ASSERT_SVH
`define RTP_JITTER_SLOT_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define RJST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtp jitter slot tracker: assertion failed");

// Next-cycle implication.
`define RJST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtp jitter slot tracker: assertion failed");

`endif

/* src/rjst_pkg.sv */
package rjst_pkg;

    // Default sizing of the slot table.
    localparam int SLOT_COUNT_DEF  = 64;
    localparam int MAX_PAYLOAD_DEF = 4000;

    // Fixed field widths.
    localparam int CMD_W  = 2;
    localparam int SEQ_W  = 16;
    localparam int LEN_W  = 12;
    localparam int SLOT_W = 6;
    localparam int LOSS_W = 32;

    // Command codes; the remaining code changes no tracker state but is still answered, as a miss.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2
    } t_cmd;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_MUL,
        ST_LOOK,
        ST_EVAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_en;
        logic load_en;
        logic mul_en;
        logic look_en;
        logic eval_en;
    } t_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic out_busy;
    } t_stat;

endpackage

/* src/rjst_if.sv */
// Command channel: one transaction per command.
interface rjst_in_if;
    import rjst_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] seq_number;
    logic [LEN_W-1:0] payload_length;

    modport source (output valid, output cmd, output seq_number, output payload_length,
                    input ready);
    modport sink   (input valid, input cmd, input seq_number, input payload_length,
                    output ready);
endinterface

// Result channel: one transaction per command.
interface rjst_out_if;
    import rjst_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot_index;
    logic [LEN_W-1:0]  found_length;
    logic [SEQ_W-1:0]  expected_next;
    logic [LOSS_W-1:0] loss_total;

    modport source (output valid, output hit, output slot_index, output found_length,
                    output expected_next, output loss_total, input ready);
    modport sink   (input valid, input hit, input slot_index, input found_length,
                    input expected_next, input loss_total, output ready);
endinterface

/* src/rjst_ctrl.sv */
`include "rtp_jitter_slot_tracker_assert.svh"

module rjst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  rjst_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output rjst_pkg::t_ctrl o_ctrl
);
    import rjst_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: clear the valid marks, then one command at a time.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                if (i_stat.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_LOOK;
            end
            ST_LOOK: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!i_stat.out_busy) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb begin
        o_in_ready     = 1'b0;
        o_ctrl         = '0;
        case (r_state)
            ST_CLR: begin
                o_ctrl.clr_en = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctrl.load_en = i_in_valid;
            end
            ST_MUL: begin
                o_ctrl.mul_en = 1'b1;
            end
            ST_LOOK: begin
                o_ctrl.look_en = 1'b1;
            end
            ST_EVAL: begin
                o_ctrl.eval_en = !i_stat.out_busy;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

    // A result is only written into a free output register.
    `RJST_ASSERT_IMP(a_eval_free, o_ctrl.eval_en, !i_stat.out_busy)
    // A finished command returns to idle.
    `RJST_ASSERT_NXT(a_eval_done, o_ctrl.eval_en, r_state == ST_IDLE)

endmodule

/* src/rjst_datapath.sv */
`include "rtp_jitter_slot_tracker_assert.svh"

module rjst_datapath #(
    parameter int SLOT_COUNT  = rjst_pkg::SLOT_COUNT_DEF,
    parameter int MAX_PAYLOAD = rjst_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rjst_pkg::t_ctrl               i_ctrl,
    output rjst_pkg::t_stat               o_stat,
    input  logic [rjst_pkg::CMD_W-1:0]    i_cmd,
    input  logic [rjst_pkg::SEQ_W-1:0]    i_seq_number,
    input  logic [rjst_pkg::LEN_W-1:0]    i_payload_length,
    input  logic                          i_out_ready,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [rjst_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [rjst_pkg::LEN_W-1:0]    o_found_length,
    output logic [rjst_pkg::SEQ_W-1:0]    o_expected_next,
    output logic [rjst_pkg::LOSS_W-1:0]   o_loss_total
);
    import rjst_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    // Reciprocal of the slot count, scaled by 2^32 and rounded down.
    localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / SLOT_COUNT;
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

    // Slot table memories.
    logic             r_vld_mem [SLOT_COUNT];
    logic [SEQ_W-1:0] r_tag_mem [SLOT_COUNT];
    logic [LEN_W-1:0] r_len_mem [SLOT_COUNT];

    // Command being worked on.
    logic [CMD_W-1:0] r_cmd;
    logic [SEQ_W-1:0] r_key;
    logic [LEN_W-1:0] r_len;
    logic [SEQ_W-1:0] r_quot;
    logic [SW-1:0]    r_slot;
    logic             r_rd_valid;
    logic [SEQ_W-1:0] r_rd_tag;
    logic [LEN_W-1:0] r_rd_len;

    // Tracker state.
    logic [SEQ_W-1:0]  r_exp_seq,     n_exp_seq;
    logic              r_started,     n_started;
    logic [CW-1:0]     r_valid_count, n_valid_count;
    logic [LOSS_W-1:0] r_loss,        n_loss;
    logic [SW-1:0]     r_clr_idx;

    // Output register.
    logic              r_out_valid;
    logic              r_out_hit;
    logic [SLOT_W-1:0] r_out_slot;
    logic [LEN_W-1:0]  r_out_len;
    logic [SEQ_W-1:0]  r_out_exp;
    logic [LOSS_W-1:0] r_out_loss;

    logic [47:0]       w_prod;
    logic [31:0]       w_qn;
    logic [31:0]       w_rem;
    logic [31:0]       w_rem_fix;
    logic [SW-1:0]     w_addr;
    logic              w_match;
    logic              w_vld_wr;
    logic              w_vld_data;
    logic              w_entry_wr;
    logic              w_res_hit;
    logic              w_res_slot_en;
    logic [15:0]       w_slot_wide;
    logic              w_clr_done;

    assign w_clr_done = (r_clr_idx == SW'(SLOT_COUNT - 1));
    assign o_stat.clr_done = w_clr_done;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    // Clearing pass over the valid marks after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_ctrl.clr_en && !w_clr_done) begin
            r_clr_idx <= r_clr_idx + SW'(1);
        end
    end

    // Take the command; a pop looks up the expected sequence number.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_en) begin
            r_cmd <= i_cmd;
            r_key <= (i_cmd == CMD_POP) ? r_exp_seq : i_seq_number;
            r_len <= (i_payload_length > LEN_MAX) ? LEN_MAX : i_payload_length;
        end
    end

    // Quotient estimate by the scaled reciprocal; it is exact or one short.
    assign w_prod = 48'(r_key) * 48'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_quot <= w_prod[47:32];
        end
    end

    // Remainder with one correction gives the slot.
    assign w_qn      = 32'(r_quot) * 32'(SLOT_COUNT);
    assign w_rem     = 32'(r_key) - w_qn;
    assign w_rem_fix = (w_rem >= 32'(SLOT_COUNT)) ? w_rem - 32'(SLOT_COUNT) : w_rem;
    assign w_addr    = w_rem_fix[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.look_en) begin
            r_slot <= w_addr;
        end
    end

    // Valid marks: cleared by the sweep, read at lookup, written at evaluation.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_en) begin
            r_vld_mem[r_clr_idx] <= 1'b0;
        end else if (w_vld_wr) begin
            r_vld_mem[r_slot] <= w_vld_data;
        end
        if (i_ctrl.look_en) begin
            r_rd_valid <= r_vld_mem[w_addr];
        end
    end

    // Tags and lengths are written by insert only.
    always_ff @(posedge i_clk) begin
        if (w_entry_wr) begin
            r_tag_mem[r_slot] <= r_key;
            r_len_mem[r_slot] <= r_len;
        end
        if (i_ctrl.look_en) begin
            r_rd_tag <= r_tag_mem[w_addr];
            r_rd_len <= r_len_mem[w_addr];
        end
    end

    assign w_match = r_rd_valid && (r_rd_tag == r_key);

    // Evaluation of the command against the slot that was read.
    always_comb begin
        n_exp_seq     = r_exp_seq;
        n_started     = r_started;
        n_valid_count = r_valid_count;
        n_loss        = r_loss;
        w_vld_wr      = 1'b0;
        w_vld_data    = 1'b0;
        w_entry_wr    = 1'b0;
        w_res_hit     = 1'b0;
        w_res_slot_en = 1'b0;
        case (r_cmd)
            CMD_INSERT: begin
                if (!r_started) begin
                    n_exp_seq = r_key;
                    n_started = 1'b1;
                end
                if (!r_rd_valid) n_valid_count = r_valid_count + CW'(1);
                w_vld_wr      = i_ctrl.eval_en;
                w_vld_data    = 1'b1;
                w_entry_wr    = i_ctrl.eval_en;
                w_res_slot_en = 1'b1;
            end
            CMD_POP: begin
                if (r_started) begin
                    if (w_match) begin
                        w_res_hit     = 1'b1;
                        w_res_slot_en = 1'b1;
                        w_vld_wr      = i_ctrl.eval_en;
                        if (r_valid_count != '0) n_valid_count = r_valid_count - CW'(1);
                        n_exp_seq = r_exp_seq + SEQ_W'(1);
                    end else if (r_valid_count != '0) begin
                        if (r_loss != '1) n_loss = r_loss + LOSS_W'(1);
                        n_exp_seq = r_exp_seq + SEQ_W'(1);
                    end
                end
            end
            CMD_PEEK: begin
                w_res_hit     = w_match;
                w_res_slot_en = w_match;
            end
            default: begin
                w_res_hit = 1'b0;
            end
        endcase
    end

    // Tracker state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_seq     <= '0;
            r_started     <= 1'b0;
            r_valid_count <= '0;
            r_loss        <= '0;
        end else if (i_ctrl.eval_en) begin
            r_exp_seq     <= n_exp_seq;
            r_started     <= n_started;
            r_valid_count <= n_valid_count;
            r_loss        <= n_loss;
        end
    end

    assign w_slot_wide = 16'(r_slot);

    // Result register, held until the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.eval_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.eval_en) begin
            r_out_hit  <= w_res_hit;
            r_out_slot <= w_res_slot_en ? w_slot_wide[SLOT_W-1:0] : '0;
            r_out_len  <= w_res_hit ? r_rd_len : '0;
            r_out_exp  <= n_exp_seq;
            r_out_loss <= n_loss;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_slot_index    = r_out_slot;
    assign o_found_length  = r_out_len;
    assign o_expected_next = r_out_exp;
    assign o_loss_total    = r_out_loss;

    // The occupancy count never exceeds the table size.
    `RJST_ASSERT_IMP(a_count_max, 1'b1, r_valid_count <= CW'(SLOT_COUNT))
    // Every evaluated command leaves a result waiting.
    `RJST_ASSERT_NXT(a_result_up, i_ctrl.eval_en, r_out_valid)

endmodule

/* src/rtp_jitter_slot_tracker.sv */
// Slot bookkeeping for an RTP jitter buffer. Each packet lives in slot
// (sequence number mod SLOT_COUNT), which holds its tag, its clamped length
// and a valid mark; the payload itself sits in an external memory addressed
// by the slot index reported here. Commands are insert, pop of the expected
// packet and peek, each answered by exactly one result transaction. A command
// passes through these steps before the next is accepted: it is taken, the
// reciprocal multiply of the modulo runs, the remainder is formed and the
// slot table read, and the command is evaluated and written back. The single
// read and write port of the slot table and the modulo unit serve one command
// at a time. A result may wait in the output register; the next command can
// still be accepted, but its evaluation is held until the register is free.
// After reset a clearing pass resets the valid marks before the first command
// is accepted.
module rtp_jitter_slot_tracker #(
    parameter int SLOT_COUNT  = rjst_pkg::SLOT_COUNT_DEF,
    parameter int MAX_PAYLOAD = rjst_pkg::MAX_PAYLOAD_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rjst_in_if.sink   i_pkt,
    rjst_out_if.source o_res
);
    import rjst_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_pkt.ready = w_in_ready;

    // Sequencing of each command.
    rjst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pkt.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_ctrl     (w_ctrl)
    );

    // Slot table, modulo unit and result register.
    rjst_datapath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (w_ctrl),
        .o_stat           (w_stat),
        .i_cmd            (i_pkt.cmd),
        .i_seq_number     (i_pkt.seq_number),
        .i_payload_length (i_pkt.payload_length),
        .i_out_ready      (o_res.ready),
        .o_valid          (o_res.valid),
        .o_hit            (o_res.hit),
        .o_slot_index     (o_res.slot_index),
        .o_found_length   (o_res.found_length),
        .o_expected_next  (o_res.expected_next),
        .o_loss_total     (o_res.loss_total)
    );

endmodule
